/* src/fsd_pkg.sv */
package fsd_pkg;

    localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
    // the prime is 2^40 + 0x1b3
    localparam int unsigned FNV_PRIME_SHIFT  = 40;
    localparam logic [8:0]  FNV_PRIME_LOW    = 9'h1b3;
    localparam logic [63:0] GOLDEN_STEP      = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A        = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B        = 64'h94d049bb133111eb;

    localparam int unsigned DIGEST_LEN_W     = 7;
    localparam logic [DIGEST_LEN_W-1:0] DIGEST_BYTES_RESET = 7'd32;
    localparam logic [DIGEST_LEN_W-1:0] DIGEST_BYTES_MAX   = 7'd64;
    localparam logic [DIGEST_LEN_W-1:0] WORD_BYTES         = 7'd8;

    localparam int unsigned APB_ADDR_W       = 3;
    localparam logic        REG_DIGEST_BYTES = 1'b0;

    typedef enum logic [1:0] {
        ACT_ABSORB  = 2'd0,
        ACT_EMIT    = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_MUL_LL,
        S_MUL_LH,
        S_MUL_HL,
        S_MIX,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ABSORB,
        OP_RESTART,
        OP_SEED,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_MIX,
        OP_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       use_b;
        logic       first;
        logic [3:0] valid_bytes;
        logic       last;
    } t_dp_cmd;

endpackage

/* src/fnv1a64_splitmix_digest_top.sv */
// 64-bit FNV-1a byte hash with a splitmix64 digest expander. Each input transfer carries an
// action in tuser (absorb, emit, restart) and a byte in tdata. Absorb and restart never stall
// the input, so bytes can stream in at one per clock while no emit is running. An emit expands
// the running hash into digest_bytes bytes (APB register at offset 0, 1..64, values outside
// clamped) as 64-bit words, first byte lowest, with the valid byte count in tuser and tlast on
// the final word. Each word steps the emit sequencer through seed, LL, LH, HL, mix, LL, LH, HL
// and out, paced by the single shared 32x32 multiplier that builds each of the two 64-bit mix
// multiplies from three partial products; input is held off for the whole emit, also while
// the output register is not drained. A finished word waits there while new input is taken.
module fnv1a64_splitmix_digest_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // data_byte
    input  logic [1:0]                      i_s_tuser,   // action
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [63:0]                     o_m_tdata,   // digest_word
    output logic [3:0]                      o_m_tuser,   // valid_bytes
    output logic                            o_m_tlast,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [fsd_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [31:0]                     i_pwdata,
    output logic [31:0]                     o_prdata,
    output logic                            o_pready
);

    logic [fsd_pkg::DIGEST_LEN_W-1:0] r_digest_bytes;
    logic                             w_reg_sel;
    fsd_pkg::t_dp_cmd                 w_cmd;
    logic                             w_out_free;

    assign o_pready  = 1'b1;
    assign w_reg_sel = (i_paddr[2] == fsd_pkg::REG_DIGEST_BYTES);
    assign o_prdata  = w_reg_sel ? {25'd0, r_digest_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest_bytes <= fsd_pkg::DIGEST_BYTES_RESET;
        end else if (i_psel && i_penable && i_pwrite && w_reg_sel) begin
            r_digest_bytes <= i_pwdata[fsd_pkg::DIGEST_LEN_W-1:0];
        end
    end

    fsd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_action       (i_s_tuser),
        .i_digest_bytes (r_digest_bytes),
        .i_out_free     (w_out_free),
        .o_s_tready     (o_s_tready),
        .o_cmd          (w_cmd)
    );

    fsd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_out_free  (w_out_free),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

/* src/fsd_ctrl.sv */
module fsd_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic [1:0]                         i_action,
    input  logic [fsd_pkg::DIGEST_LEN_W-1:0]   i_digest_bytes,
    input  logic                               i_out_free,
    output logic                               o_s_tready,
    output fsd_pkg::t_dp_cmd                   o_cmd
);

    fsd_pkg::t_state                     r_state, n_state;
    logic                                r_use_b, n_use_b;
    logic                                r_first, n_first;
    logic [fsd_pkg::DIGEST_LEN_W-1:0]    r_remain, n_remain;
    logic [fsd_pkg::DIGEST_LEN_W-1:0]    w_total;
    logic                                w_emit;
    logic                                w_last;
    logic [3:0]                          w_valid_bytes;

    always_comb begin
        if (i_digest_bytes == '0) begin
            w_total = fsd_pkg::DIGEST_LEN_W'(1);
        end else if (i_digest_bytes > fsd_pkg::DIGEST_BYTES_MAX) begin
            w_total = fsd_pkg::DIGEST_BYTES_MAX;
        end else begin
            w_total = i_digest_bytes;
        end
    end

    assign w_emit        = i_s_tvalid && (i_action == fsd_pkg::ACT_EMIT);
    assign w_last        = (r_remain <= fsd_pkg::WORD_BYTES);
    assign w_valid_bytes = w_last ? r_remain[3:0] : 4'd8;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsd_pkg::S_IDLE: begin
                if (w_emit) n_state = fsd_pkg::S_SEED;
            end
            fsd_pkg::S_SEED:   n_state = fsd_pkg::S_MUL_LL;
            fsd_pkg::S_MUL_LL: n_state = fsd_pkg::S_MUL_LH;
            fsd_pkg::S_MUL_LH: n_state = fsd_pkg::S_MUL_HL;
            fsd_pkg::S_MUL_HL: n_state = r_use_b ? fsd_pkg::S_OUT : fsd_pkg::S_MIX;
            fsd_pkg::S_MIX:    n_state = fsd_pkg::S_MUL_LL;
            fsd_pkg::S_OUT: begin
                if (i_out_free) n_state = w_last ? fsd_pkg::S_IDLE : fsd_pkg::S_SEED;
            end
            default:           n_state = fsd_pkg::S_IDLE;
        endcase
    end

    // word counter and phase
    always_comb begin
        n_use_b  = r_use_b;
        n_first  = r_first;
        n_remain = r_remain;
        unique case (r_state)
            fsd_pkg::S_IDLE: begin
                if (w_emit) begin
                    n_first  = 1'b1;
                    n_remain = w_total;
                end
            end
            fsd_pkg::S_SEED: n_use_b = 1'b0;
            fsd_pkg::S_MIX:  n_use_b = 1'b1;
            fsd_pkg::S_OUT: begin
                if (i_out_free) begin
                    n_first  = 1'b0;
                    n_remain = r_remain - fsd_pkg::WORD_BYTES;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready        = 1'b0;
        o_cmd.op          = fsd_pkg::OP_NONE;
        o_cmd.use_b       = r_use_b;
        o_cmd.first       = r_first;
        o_cmd.valid_bytes = w_valid_bytes;
        o_cmd.last        = w_last;
        unique case (r_state)
            fsd_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    unique case (i_action)
                        fsd_pkg::ACT_ABSORB:  o_cmd.op = fsd_pkg::OP_ABSORB;
                        fsd_pkg::ACT_RESTART: o_cmd.op = fsd_pkg::OP_RESTART;
                        default:              o_cmd.op = fsd_pkg::OP_NONE;
                    endcase
                end
            end
            fsd_pkg::S_SEED:   o_cmd.op = fsd_pkg::OP_SEED;
            fsd_pkg::S_MUL_LL: o_cmd.op = fsd_pkg::OP_MUL_LL;
            fsd_pkg::S_MUL_LH: o_cmd.op = fsd_pkg::OP_MUL_LH;
            fsd_pkg::S_MUL_HL: o_cmd.op = fsd_pkg::OP_MUL_HL;
            fsd_pkg::S_MIX:    o_cmd.op = fsd_pkg::OP_MIX;
            fsd_pkg::S_OUT: begin
                if (i_out_free) o_cmd.op = fsd_pkg::OP_LOAD;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fsd_pkg::S_IDLE;
            r_use_b  <= 1'b0;
            r_first  <= 1'b0;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_use_b  <= n_use_b;
            r_first  <= n_first;
            r_remain <= n_remain;
        end
    end

endmodule

/* src/fsd_dpath.sv */
module fsd_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fsd_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_data_byte,
    input  logic             i_m_tready,
    output logic             o_out_free,
    output logic             o_m_tvalid,
    output logic [63:0]      o_m_tdata,
    output logic [3:0]       o_m_tuser,
    output logic             o_m_tlast
);

    logic [63:0] r_hash;
    logic [63:0] r_x;
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [3:0]  r_out_bytes;
    logic        r_out_last;

    logic [63:0] w_fold;
    logic [63:0] w_fnv;
    logic [63:0] w_x_next;
    logic [63:0] w_k;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_word;
    logic [63:0] w_masked;

    assign w_fold   = r_hash ^ {56'd0, i_data_byte};
    assign w_fnv    = (w_fold << fsd_pkg::FNV_PRIME_SHIFT)
                    + (w_fold * {55'd0, fsd_pkg::FNV_PRIME_LOW});
    assign w_x_next = (i_cmd.first ? r_hash : r_x) + fsd_pkg::GOLDEN_STEP;

    // one shared 32x32 multiplier, three partial products per 64-bit multiply
    assign w_k     = i_cmd.use_b ? fsd_pkg::MIX_MUL_B : fsd_pkg::MIX_MUL_A;
    assign w_mul_a = (i_cmd.op == fsd_pkg::OP_MUL_HL) ? r_z[63:32] : r_z[31:0];
    assign w_mul_b = (i_cmd.op == fsd_pkg::OP_MUL_LH) ? w_k[63:32] : w_k[31:0];
    assign w_prod  = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    assign w_word = r_acc ^ (r_acc >> 31);

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_masked[b*8 +: 8] = (4'(b) < i_cmd.valid_bytes) ? w_word[b*8 +: 8] : 8'd0;
        end
    end

    assign o_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= fsd_pkg::FNV_OFFSET_BASIS;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == fsd_pkg::OP_ABSORB) begin
                r_hash <= w_fnv;
            end else if (i_cmd.op == fsd_pkg::OP_RESTART) begin
                r_hash <= fsd_pkg::FNV_OFFSET_BASIS;
            end
            if (i_cmd.op == fsd_pkg::OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            fsd_pkg::OP_SEED: begin
                r_x <= w_x_next;
                r_z <= w_x_next ^ (w_x_next >> 30);
            end
            fsd_pkg::OP_MUL_LL: r_acc <= w_prod;
            fsd_pkg::OP_MUL_LH,
            fsd_pkg::OP_MUL_HL: r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            fsd_pkg::OP_MIX:    r_z <= r_acc ^ (r_acc >> 27);
            fsd_pkg::OP_LOAD: begin
                r_out_data  <= w_masked;
                r_out_bytes <= i_cmd.valid_bytes;
                r_out_last  <= i_cmd.last;
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_bytes;
    assign o_m_tlast  = r_out_last;

endmodule

/* src/fsd_checker.sv */
module fsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,
    input  logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] o_m_tdata,
    input  logic [3:0]  o_m_tuser,
    input  logic        o_m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output changed while stalled");

    // only the final word may be partial
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser == 4'd8)
        else $error("partial word without tlast");

    // byte count in range and bytes above it zero
    a_byte_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser != 4'd0 && o_m_tuser <= 4'd8
                       && (o_m_tuser == 4'd8
                           || (o_m_tdata >> {o_m_tuser, 3'b000}) == 64'd0))
        else $error("bad byte count or unmasked bytes");

    // an emit transfer occupies the sequencer
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == fsd_pkg::ACT_EMIT |=> !o_s_tready)
        else $error("input taken right after emit");

endmodule

bind fnv1a64_splitmix_digest_top fsd_checker u_fsd_checker (.*);
